// ===== src/assert_macros.svh =====
// Assertion macros shared by the voxel frame buffer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that cons holds in the same cycle as ante
`define VFB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("voxel frame buffer assertion failed");

// check that cons holds in the cycle after ante
`define VFB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("voxel frame buffer assertion failed");

`endif

// ===== src/vfb_pkg.sv =====
// Types and constants of the voxel frame buffer engine.
`default_nettype none

package vfb_pkg;

  localparam int EDGE      = 8;
  localparam int COORD_W   = 3;
  localparam int BUF_BYTES = EDGE * EDGE;
  localparam int IDX_W     = 6;
  localparam int ADDR_W    = IDX_W + 1;
  localparam int STORE_BYTES = 2 * BUF_BYTES;
  localparam int CNT_W     = IDX_W + 1;

  typedef logic [3:0] cmd_t;
  localparam cmd_t CMD_WRITE  = 4'd0;
  localparam cmd_t CMD_INVERT = 4'd1;
  localparam cmd_t CMD_READ   = 4'd2;
  localparam cmd_t CMD_PLANE  = 4'd3;
  localparam cmd_t CMD_SHIFT  = 4'd4;
  localparam cmd_t CMD_MIRROR = 4'd5;
  localparam cmd_t CMD_FILL   = 4'd6;
  localparam cmd_t CMD_SWAP   = 4'd7;
  localparam cmd_t CMD_SELECT = 4'd8;

  typedef logic [1:0] axis_t;
  localparam axis_t AXIS_X    = 2'd0;
  localparam axis_t AXIS_Y    = 2'd1;
  localparam axis_t AXIS_Z    = 2'd2;
  localparam axis_t AXIS_NONE = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_MAP,
    ST_DONE
  } st_t;

  typedef enum logic [2:0] {
    BOP_PASS,
    BOP_OR,
    BOP_ANDN,
    BOP_XOR,
    BOP_LOAD,
    BOP_ROL,
    BOP_ROR,
    BOP_REV
  } bop_t;

  typedef struct packed {
    bop_t       op;
    logic [7:0] mask;
    logic [7:0] konst;
  } bu_ctl_t;

endpackage

`default_nettype wire

// ===== src/voxel_frame_buffer_engine.sv =====
// Top level of the double-buffered voxel frame buffer engine.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_ready   | cmd x y z axis plane_pos turn_on direction pattern
//   out     | output    | out_valid/out_ready | voxel_on
//
// Write, invert and read touch one row; swap, select, no-op and axis-three commands touch none.
// Plane, fill, X shift and X mirror sweep the whole buffer, one row byte per cycle through
// the single read and single write port of the frame memory.
// Y and Z shift and mirror make a copy into scratch, then a permuted write back.
// Reset clears per-row valid bits at once, so both buffers read as zero without a clearing pass.
// The result waits in an output register; a new command is taken as soon as the engine is idle.
`default_nettype none

module voxel_frame_buffer_engine
  import vfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] in_cmd,
  input  logic [2:0] in_x,
  input  logic [2:0] in_y,
  input  logic [2:0] in_z,
  input  logic [1:0] in_axis,
  input  logic [2:0] in_plane_pos,
  input  logic       in_turn_on,
  input  logic       in_direction,
  input  logic [7:0] in_pattern,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_voxel_on
);

  `include "assert_macros.svh"

  st_t                state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               pend_r;
  logic [IDX_W-1:0]   wr_idx_r;
  cmd_t               cmd_r;
  logic [COORD_W-1:0] x_r, y_r, z_r, pos_r;
  axis_t              axis_r;
  logic               on_r, dir_r;
  logic [7:0]         pattern_r;
  logic               single_r, use_scratch_r;
  logic               half_r;
  logic               front_r, back_r;
  logic               res_r;
  logic               out_valid_r, out_voxel_on_r;

  logic               accept, issue, sweep_end, load_out;
  logic               main_we, scratch_we;
  logic [CNT_W-1:0]   limit;
  logic [IDX_W-1:0]   cur_idx, src_idx;
  logic [COORD_W-1:0] cz, cy, sz, sy;
  logic [7:0]         main_rdata, scratch_rdata, bu_din, bu_dout;
  bu_ctl_t            bu_ctl;

  assign accept    = in_valid && in_ready;
  assign limit     = single_r ? CNT_W'(1) : CNT_W'(BUF_BYTES);
  assign sweep_end = !issue && !pend_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_cmd) inside
            CMD_WRITE, CMD_INVERT, CMD_READ, CMD_FILL: state_nxt = ST_MAP;
            CMD_PLANE: state_nxt = (in_axis == AXIS_NONE) ? ST_DONE : ST_MAP;
            CMD_SHIFT, CMD_MIRROR: begin
              if (in_axis == AXIS_NONE) state_nxt = ST_DONE;
              else if (in_axis == AXIS_X) state_nxt = ST_MAP;
              else state_nxt = ST_COPY;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_COPY: if (sweep_end) state_nxt = ST_MAP;
      ST_MAP:  if (sweep_end) state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    issue      = 1'b0;
    main_we    = 1'b0;
    scratch_we = 1'b0;
    load_out   = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = rst_n;
      ST_COPY: begin
        issue      = cnt_r < limit;
        scratch_we = pend_r;
      end
      ST_MAP: begin
        issue   = cnt_r < limit;
        main_we = pend_r && (cmd_r != CMD_READ);
      end
      ST_DONE: load_out = !out_valid_r || out_ready;
      default: in_ready = 1'b0;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = '0;
    end else if (state_r == ST_COPY && sweep_end) begin
      cnt_nxt = '0;
    end else if (issue) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  assign cur_idx = single_r ? {z_r, y_r} : cnt_r[IDX_W-1:0];
  assign cz      = cur_idx[IDX_W-1:COORD_W];
  assign cy      = cur_idx[COORD_W-1:0];

  always_comb begin
    sz = cz;
    sy = cy;
    if (cmd_r == CMD_SHIFT) begin
      if (axis_r == AXIS_Y) sy = dir_r ? cy + 3'd7 : cy + 3'd1;
      if (axis_r == AXIS_Z) sz = dir_r ? cz + 3'd7 : cz + 3'd1;
    end else begin
      if (axis_r == AXIS_Y) sy = ~cy;
      if (axis_r == AXIS_Z) sz = ~cz;
    end
  end

  assign src_idx = {sz, sy};

  always_comb begin
    bu_ctl.op    = BOP_PASS;
    bu_ctl.mask  = 8'b1 << ((cmd_r == CMD_PLANE) ? pos_r : x_r);
    bu_ctl.konst = (cmd_r == CMD_FILL) ? pattern_r : {8{on_r}};
    case (cmd_r)
      CMD_WRITE:  bu_ctl.op = on_r ? BOP_OR : BOP_ANDN;
      CMD_INVERT: bu_ctl.op = BOP_XOR;
      CMD_PLANE: begin
        if (axis_r == AXIS_X) begin
          bu_ctl.op = on_r ? BOP_OR : BOP_ANDN;
        end else if (axis_r == AXIS_Y) begin
          bu_ctl.op = (wr_idx_r[COORD_W-1:0] == pos_r) ? BOP_LOAD : BOP_PASS;
        end else if (axis_r == AXIS_Z) begin
          bu_ctl.op = (wr_idx_r[IDX_W-1:COORD_W] == pos_r) ? BOP_LOAD : BOP_PASS;
        end
      end
      CMD_SHIFT:  if (axis_r == AXIS_X) bu_ctl.op = dir_r ? BOP_ROL : BOP_ROR;
      CMD_MIRROR: if (axis_r == AXIS_X) bu_ctl.op = BOP_REV;
      CMD_FILL:   bu_ctl.op = BOP_LOAD;
      default:    bu_ctl.op = BOP_PASS;
    endcase
  end

  assign bu_din = use_scratch_r ? scratch_rdata : main_rdata;

  vfb_byte_unit u_byte_unit (
    .ctl  (bu_ctl),
    .din  (bu_din),
    .dout (bu_dout)
  );

  vfb_frame_ram u_frame_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (main_we),
    .waddr ({half_r, wr_idx_r}),
    .wdata (bu_dout),
    .raddr ({half_r, cur_idx}),
    .rdata (main_rdata)
  );

  vfb_scratch_ram u_scratch_ram (
    .clk   (clk),
    .we    (scratch_we),
    .waddr (wr_idx_r),
    .wdata (main_rdata),
    .raddr (src_idx),
    .rdata (scratch_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      front_r     <= 1'b0;
      back_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= issue;
      if (accept && in_cmd == CMD_SWAP) front_r <= ~front_r;
      if (accept && in_cmd == CMD_SELECT) back_r <= in_turn_on;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_idx_r <= cur_idx;
    if (accept) begin
      cmd_r         <= in_cmd;
      x_r           <= in_x;
      y_r           <= in_y;
      z_r           <= in_z;
      axis_r        <= in_axis;
      pos_r         <= in_plane_pos;
      on_r          <= in_turn_on;
      dir_r         <= in_direction;
      pattern_r     <= in_pattern;
      half_r        <= front_r ^ back_r;
      single_r      <= (in_cmd == CMD_WRITE) || (in_cmd == CMD_INVERT) ||
                       (in_cmd == CMD_READ);
      use_scratch_r <= ((in_cmd == CMD_SHIFT) || (in_cmd == CMD_MIRROR)) &&
                       ((in_axis == AXIS_Y) || (in_axis == AXIS_Z));
      res_r         <= 1'b0;
    end else if (state_r == ST_MAP && pend_r && cmd_r == CMD_READ) begin
      res_r <= main_rdata[x_r];
    end
    if (load_out) begin
      out_voxel_on_r <= res_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_voxel_on = out_voxel_on_r;

  `VFB_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(BUF_BYTES))
  `VFB_ASSERT_SAME(a_map_drained, state_r == ST_MAP && state_nxt == ST_DONE, !pend_r)
  `VFB_ASSERT_SAME(a_copy_no_frame_write, state_r == ST_COPY, !main_we)
  `VFB_ASSERT_NEXT(a_swap_flips, accept && in_cmd == CMD_SWAP, front_r != $past(front_r))

endmodule

`default_nettype wire

// ===== src/vfb_byte_unit.sv =====
// Shared row byte unit: bit set/clear/toggle, load, rotate and reverse.
`default_nettype none

module vfb_byte_unit
  import vfb_pkg::*;
(
  input  bu_ctl_t    ctl,
  input  logic [7:0] din,
  output logic [7:0] dout
);

  logic [7:0] rev;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rev[i] = din[7 - i];
    end
  end

  always_comb begin
    case (ctl.op)
      BOP_PASS: dout = din;
      BOP_OR:   dout = din | ctl.mask;
      BOP_ANDN: dout = din & ~ctl.mask;
      BOP_XOR:  dout = din ^ ctl.mask;
      BOP_LOAD: dout = ctl.konst;
      BOP_ROL:  dout = {din[6:0], din[7]};
      BOP_ROR:  dout = {din[0], din[7:1]};
      BOP_REV:  dout = rev;
      default:  dout = din;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/vfb_frame_ram.sv =====
// Frame store of both buffers with per-row valid bits that read as zero after reset.
`default_nettype none

module vfb_frame_ram
  import vfb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0]             mem_r [STORE_BYTES];
  logic [STORE_BYTES-1:0] valid_r;
  logic [7:0]             rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= valid_r[raddr] ? mem_r[raddr] : 8'h00;
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== src/vfb_scratch_ram.sv =====
// Scratch copy of one buffer for row and plane permutations.
`default_nettype none

module vfb_scratch_ram
  import vfb_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  logic [7:0]       wdata,
  input  logic [IDX_W-1:0] raddr,
  output logic [7:0]       rdata
);

  logic [7:0] mem_r [BUF_BYTES];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== verif/voxel_cube_checker.sv =====
// Checker for the voxel frame buffer engine: tracks both buffers and compares every result.
`timescale 1ns / 100ps

module voxel_cube_checker
  import vfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [3:0] in_cmd,
  input  logic [2:0] in_x,
  input  logic [2:0] in_y,
  input  logic [2:0] in_z,
  input  logic [1:0] in_axis,
  input  logic [2:0] in_plane_pos,
  input  logic       in_turn_on,
  input  logic       in_direction,
  input  logic [7:0] in_pattern,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       out_voxel_on,
  output int         fail_count,
  output int         outstanding
);

  logic [7:0] cube_rows [0:STORE_BYTES-1];
  logic       front_upper;
  logic       target_back;
  logic       voxel_on_expected [$];
  logic       want;
  int         mismatches = 0;

  assign fail_count = mismatches;

  function automatic logic apply_voxel_cmd(cmd_t c, logic [2:0] x, logic [2:0] y,
                                           logic [2:0] z, axis_t ax, logic [2:0] pos,
                                           logic on, logic fwd, logic [7:0] pat);
    logic [7:0] snap [0:BUF_BYTES-1];
    logic [7:0] bit_mask;
    logic [7:0] v;
    logic [7:0] rev;
    logic       hit;
    int         base;
    int         row;
    int         src;
    base = (front_upper ^ target_back) ? BUF_BYTES : 0;
    row = base + z * EDGE + y;
    bit_mask = 8'h01 << x;
    hit = 1'b0;
    for (int i = 0; i < BUF_BYTES; i++) snap[i] = cube_rows[base + i];
    case (c)
      CMD_WRITE: begin
        if (on) cube_rows[row] = cube_rows[row] | bit_mask;
        else cube_rows[row] = cube_rows[row] & ~bit_mask;
      end
      CMD_INVERT: cube_rows[row] = cube_rows[row] ^ bit_mask;
      CMD_READ: hit = |(cube_rows[row] & bit_mask);
      CMD_PLANE: begin
        for (int zi = 0; zi < EDGE; zi++) begin
          for (int yi = 0; yi < EDGE; yi++) begin
            src = base + zi * EDGE + yi;
            case (ax)
              AXIS_X: begin
                if (on) cube_rows[src] = cube_rows[src] | (8'h01 << pos);
                else cube_rows[src] = cube_rows[src] & ~(8'h01 << pos);
              end
              AXIS_Y: if (yi == pos) cube_rows[src] = on ? 8'hff : 8'h00;
              AXIS_Z: if (zi == pos) cube_rows[src] = on ? 8'hff : 8'h00;
              default: ;
            endcase
          end
        end
      end
      CMD_SHIFT: begin
        for (int zi = 0; zi < EDGE; zi++) begin
          for (int yi = 0; yi < EDGE; yi++) begin
            v = snap[zi * EDGE + yi];
            case (ax)
              AXIS_X: cube_rows[base + zi * EDGE + yi] = fwd ? {v[6:0], v[7]} : {v[0], v[7:1]};
              AXIS_Y: begin
                src = fwd ? (yi + EDGE - 1) % EDGE : (yi + 1) % EDGE;
                cube_rows[base + zi * EDGE + yi] = snap[zi * EDGE + src];
              end
              AXIS_Z: begin
                src = fwd ? (zi + EDGE - 1) % EDGE : (zi + 1) % EDGE;
                cube_rows[base + zi * EDGE + yi] = snap[src * EDGE + yi];
              end
              default: ;
            endcase
          end
        end
      end
      CMD_MIRROR: begin
        for (int zi = 0; zi < EDGE; zi++) begin
          for (int yi = 0; yi < EDGE; yi++) begin
            v = snap[zi * EDGE + yi];
            for (int b = 0; b < 8; b++) rev[7 - b] = v[b];
            case (ax)
              AXIS_X: cube_rows[base + zi * EDGE + yi] = rev;
              AXIS_Y: cube_rows[base + zi * EDGE + yi] = snap[zi * EDGE + (EDGE - 1 - yi)];
              AXIS_Z: cube_rows[base + zi * EDGE + yi] = snap[(EDGE - 1 - zi) * EDGE + yi];
              default: ;
            endcase
          end
        end
      end
      CMD_FILL: for (int i = 0; i < BUF_BYTES; i++) cube_rows[base + i] = pat;
      CMD_SWAP: front_upper = ~front_upper;
      CMD_SELECT: target_back = on;
      default: ;
    endcase
    return hit;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STORE_BYTES; i++) cube_rows[i] = 8'h00;
      front_upper = 1'b0;
      target_back = 1'b0;
      voxel_on_expected.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (voxel_on_expected.size() == 0) begin
          $error("out transaction with nothing pending: voxel_on actual %0b", out_voxel_on);
          mismatches <= mismatches + 1;
        end else begin
          want = voxel_on_expected.pop_front();
          if (out_voxel_on !== want) begin
            $error("voxel_on mismatch: expected %0b actual %0b", want, out_voxel_on);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_valid && in_ready)
        voxel_on_expected.push_back(apply_voxel_cmd(in_cmd, in_x, in_y, in_z, in_axis,
                                                    in_plane_pos, in_turn_on, in_direction,
                                                    in_pattern));
    end
    outstanding <= voxel_on_expected.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the voxel frame buffer engine: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
  import vfb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 500;

  typedef struct packed {
    cmd_t       cmd;
    logic [2:0] x;
    logic [2:0] y;
    logic [2:0] z;
    axis_t      axis;
    logic [2:0] plane_pos;
    logic       turn_on;
    logic       direction;
    logic [7:0] pattern;
  } voxel_req_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [3:0] in_cmd = '0;
  logic [2:0] in_x = '0;
  logic [2:0] in_y = '0;
  logic [2:0] in_z = '0;
  logic [1:0] in_axis = '0;
  logic [2:0] in_plane_pos = '0;
  logic       in_turn_on = 1'b0;
  logic       in_direction = 1'b0;
  logic [7:0] in_pattern = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_voxel_on;
  int         fail_count;
  int         outstanding;
  int         idle_pct = 0;
  int         stall_pct = 0;
  int         quiet_cycles = 0;

  voxel_frame_buffer_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .in_x(in_x), .in_y(in_y), .in_z(in_z), .in_axis(in_axis),
    .in_plane_pos(in_plane_pos), .in_turn_on(in_turn_on), .in_direction(in_direction),
    .in_pattern(in_pattern),
    .out_valid(out_valid), .out_ready(out_ready), .out_voxel_on(out_voxel_on)
  );

  voxel_cube_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .in_x(in_x), .in_y(in_y), .in_z(in_z), .in_axis(in_axis),
    .in_plane_pos(in_plane_pos), .in_turn_on(in_turn_on), .in_direction(in_direction),
    .in_pattern(in_pattern),
    .out_valid(out_valid), .out_ready(out_ready), .out_voxel_on(out_voxel_on),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  always #5 clk = ~clk;

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic voxel_req_t req(cmd_t c, logic [2:0] x, logic [2:0] y, logic [2:0] z,
                                     axis_t ax, logic [2:0] pos, logic on, logic fwd,
                                     logic [7:0] pat);
    voxel_req_t r;
    r.cmd = c;
    r.x = x;
    r.y = y;
    r.z = z;
    r.axis = ax;
    r.plane_pos = pos;
    r.turn_on = on;
    r.direction = fwd;
    r.pattern = pat;
    return r;
  endfunction

  function automatic voxel_req_t random_req();
    voxel_req_t r;
    logic [31:0] raw;
    int pick;
    raw = $urandom;
    r = raw[$bits(voxel_req_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 22) r.cmd = CMD_READ;
    else if (pick < 40) r.cmd = CMD_WRITE;
    else if (pick < 50) r.cmd = CMD_INVERT;
    else if (pick < 60) r.cmd = CMD_PLANE;
    else if (pick < 70) r.cmd = CMD_SHIFT;
    else if (pick < 78) r.cmd = CMD_MIRROR;
    else if (pick < 83) r.cmd = CMD_FILL;
    else if (pick < 89) r.cmd = CMD_SWAP;
    else if (pick < 95) r.cmd = CMD_SELECT;
    else r.cmd = CMD_SELECT + cmd_t'($urandom_range(1, 7));
    r.axis = ($urandom_range(15) == 0) ? AXIS_NONE : axis_t'($urandom_range(2));
    case ($urandom_range(7))
      0: r.pattern = 8'h00;
      1: r.pattern = 8'hff;
      default: ;
    endcase
    return r;
  endfunction

  task automatic issue(voxel_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= r.cmd;
    in_x <= r.x;
    in_y <= r.y;
    in_z <= r.z;
    in_axis <= r.axis;
    in_plane_pos <= r.plane_pos;
    in_turn_on <= r.turn_on;
    in_direction <= r.direction;
    in_pattern <= r.pattern;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(req(CMD_WRITE, 3'd7, 3'd7, 3'd7, AXIS_X, 3'd0, 1'b1, 1'b0, 8'h00));
    issue(req(CMD_READ, 3'd7, 3'd7, 3'd7, AXIS_X, 3'd0, 1'b0, 1'b0, 8'h00));
    issue(req(CMD_INVERT, 3'd0, 3'd0, 3'd0, AXIS_X, 3'd0, 1'b0, 1'b0, 8'h00));
    issue(req(CMD_READ, 3'd0, 3'd0, 3'd0, AXIS_X, 3'd0, 1'b0, 1'b0, 8'h00));
    issue(req(CMD_PLANE, 3'd0, 3'd0, 3'd0, AXIS_X, 3'd7, 1'b1, 1'b0, 8'h00));
    issue(req(CMD_PLANE, 3'd0, 3'd0, 3'd0, AXIS_Y, 3'd0, 1'b1, 1'b0, 8'h00));
    issue(req(CMD_PLANE, 3'd0, 3'd0, 3'd0, AXIS_Z, 3'd7, 1'b0, 1'b0, 8'h00));
    issue(req(CMD_PLANE, 3'd0, 3'd0, 3'd0, AXIS_NONE, 3'd3, 1'b1, 1'b0, 8'h00));
    issue(req(CMD_READ, 3'd7, 3'd1, 3'd2, AXIS_X, 3'd0, 1'b0, 1'b0, 8'h00));
    issue(req(CMD_FILL, 3'd0, 3'd0, 3'd0, AXIS_X, 3'd0, 1'b0, 1'b0, 8'ha5));
    issue(req(CMD_SHIFT, 3'd0, 3'd0, 3'd0, AXIS_X, 3'd0, 1'b0, 1'b1, 8'h00));
    issue(req(CMD_SHIFT, 3'd0, 3'd0, 3'd0, AXIS_X, 3'd0, 1'b0, 1'b0, 8'h00));
    issue(req(CMD_WRITE, 3'd1, 3'd7, 3'd0, AXIS_X, 3'd0, 1'b0, 1'b0, 8'h00));
    issue(req(CMD_SHIFT, 3'd0, 3'd0, 3'd0, AXIS_Y, 3'd0, 1'b0, 1'b1, 8'h00));
    issue(req(CMD_SHIFT, 3'd0, 3'd0, 3'd0, AXIS_Z, 3'd0, 1'b0, 1'b0, 8'h00));
    issue(req(CMD_SHIFT, 3'd0, 3'd0, 3'd0, AXIS_NONE, 3'd0, 1'b0, 1'b1, 8'h00));
    issue(req(CMD_MIRROR, 3'd0, 3'd0, 3'd0, AXIS_X, 3'd0, 1'b0, 1'b0, 8'h00));
    issue(req(CMD_MIRROR, 3'd0, 3'd0, 3'd0, AXIS_Y, 3'd0, 1'b0, 1'b0, 8'h00));
    issue(req(CMD_MIRROR, 3'd0, 3'd0, 3'd0, AXIS_Z, 3'd0, 1'b0, 1'b0, 8'h00));
    issue(req(CMD_MIRROR, 3'd0, 3'd0, 3'd0, AXIS_NONE, 3'd0, 1'b0, 1'b0, 8'h00));
    issue(req(CMD_SELECT, 3'd0, 3'd0, 3'd0, AXIS_X, 3'd0, 1'b1, 1'b0, 8'h00));
    issue(req(CMD_WRITE, 3'd0, 3'd0, 3'd0, AXIS_X, 3'd0, 1'b1, 1'b0, 8'h00));
    issue(req(CMD_SWAP, 3'd0, 3'd0, 3'd0, AXIS_X, 3'd0, 1'b0, 1'b0, 8'h00));
    issue(req(CMD_SELECT, 3'd0, 3'd0, 3'd0, AXIS_X, 3'd0, 1'b0, 1'b0, 8'h00));
    issue(req(CMD_SELECT + 4'd7, 3'd5, 3'd2, 3'd6, AXIS_Z, 3'd4, 1'b1, 1'b1, 8'hff));
    issue(req(CMD_READ, 3'd0, 3'd0, 3'd0, AXIS_X, 3'd0, 1'b0, 1'b0, 8'h00));
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct <= 0;  stall_pct <= 0;  end
        1: begin idle_pct <= 55; stall_pct <= 0;  end
        2: begin idle_pct <= 0;  stall_pct <= 55; end
        default: begin idle_pct <= 28; stall_pct <= 28; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) issue(random_req());
      drain();
    end

    repeat (200) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
